// ===== rtl/core/eodo_pkg.sv =====
// Package for the encoder differential odometry unit.
// Holds the fixed-point constants, widths and register indexes.
// No dependencies.
package eodo_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Shared shift-and-add multiplier and restoring divider widths.
    localparam int MUL_A_W = 56;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_W   = 31;
    localparam int DEN_W   = 6;
    localparam int CNT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_BASE = 1'b1;

    localparam logic [31:0] DPC_RESET = 32'd26765;
    localparam logic [23:0] IWB_RESET = 24'd504123;

    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [29:0] EIGHTH     = 30'd536870912;
    localparam logic [30:0] QUARTER    = 31'd1073741824;

    localparam logic [ANGLE_BITS:0] ANG_HALF = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);

endpackage

// ===== rtl/core/encoder_differential_odometry_unit.sv =====
// Top level of the encoder differential odometry unit.
// Uses eodo_pkg for constants; contains the whole datapath and sequencer.
//
// Usage: each input item carries an absolute left and right wheel angle in
// units of 1/65536 turn, handed over on i_in_valid while o_in_stall is low.
// Each result item carries pos_x, pos_y (signed Q16.16, saturating) and the
// heading (unsigned Q0.32 turns) on o_out_valid while i_out_stall is low.
// The first item after reset only captures the angles and gives no result.
// Every later item gives exactly one result.
// All arithmetic runs through one bit-serial shift-and-add multiplier
// (with its load and finish steps) and one bit-serial restoring divider,
// used in turn by a sequencer for fourteen products and seven quotients.
// The next item is accepted as soon as the sequencer is back in its idle
// state, even while the previous result still waits in the output
// register; no new item is taken while the sequencer still works on the
// last one.
// When the receiver stalls, the finished result waits before the output
// register until the earlier one is taken, and o_in_stall stays high.
// Synchronous active-low reset clears the pose and the handshake state and
// returns the configuration registers to their reset values.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data.
module encoder_differential_odometry_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [15:0]                         i_left_angle,
    input  logic [15:0]                         i_right_angle,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_pos_x,
    output logic signed [31:0]                  o_pos_y,
    output logic [31:0]                         o_heading,
    input  logic                                i_cfg_we,
    input  logic [eodo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [eodo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_MDD, S_MIWB, S_MK, S_MR, S_MR2,
        S_DS1, S_MS1, S_DS2, S_MS2, S_DS3, S_MS0,
        S_DC1, S_MC1, S_DC2, S_MC2, S_DC3, S_MC3, S_DC4,
        S_MSUM, S_MX, S_MY, S_POST
    } t_state;

    typedef enum logic [1:0] {PH_LOAD, PH_RUN, PH_FIN} t_phase;

    t_state r_state;
    t_phase r_ph;
    logic [eodo_pkg::CNT_W-1:0] r_cnt;

    logic [31:0] r_dpc;
    logic [23:0] r_iwb;
    logic        r_started;
    logic [15:0] r_prev_l;
    logic [15:0] r_prev_r;
    logic [16:0] r_dd_mag;
    logic        r_dd_neg;
    logic [16:0] r_sum_mag;
    logic        r_sum_neg;

    logic [eodo_pkg::MUL_A_W-1:0] r_pa;
    logic [eodo_pkg::MUL_P_W-1:0] r_pp;
    logic [eodo_pkg::DIV_W-1:0]   r_dq;
    logic [eodo_pkg::DEN_W-1:0]   r_rem;
    logic [eodo_pkg::DEN_W-1:0]   r_den;

    logic [55:0] r_m;
    logic [29:0] r_r;
    logic [29:0] r_r2;
    logic [30:0] r_t;
    logic [30:0] r_s0;
    logic [30:0] r_c0;
    logic [31:0] r_head;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;

    logic        r_ovalid;
    logic [31:0] r_ox;
    logic [31:0] r_oy;
    logic [31:0] r_oh;

    // Decoded operation of the current state.
    logic                          c_is_div;
    logic [eodo_pkg::MUL_A_W-1:0]  c_a;
    logic [eodo_pkg::MUL_B_W-1:0]  c_b;
    logic [eodo_pkg::DIV_W-1:0]    c_num;
    logic [eodo_pkg::DEN_W-1:0]    c_den;
    t_state                        c_next;

    logic [eodo_pkg::MUL_A_W:0]    n_add;
    logic [eodo_pkg::MUL_P_W-1:0]  n_pp;
    logic [eodo_pkg::DEN_W:0]      n_sh;
    logic [eodo_pkg::DEN_W+1:0]    n_sub;
    logic                          n_ok;
    logic [eodo_pkg::DEN_W-1:0]    n_rem;
    logic [eodo_pkg::DIV_W-1:0]    n_dq;

    logic in_acc;
    logic signed [17:0] w_dl;
    logic signed [17:0] w_dr;
    logic signed [18:0] w_dd;
    logic signed [18:0] w_sum;

    logic [1:0]  w_quad;
    logic [29:0] w_f;
    logic        w_fold;
    logic [29:0] w_g;
    logic [30:0] w_ssel;
    logic [30:0] w_csel;
    logic [30:0] w_smag;
    logic [30:0] w_cmag;
    logic        w_sneg;
    logic        w_cneg;
    logic [31:0] w_hstep;
    logic [31:0] w_pstep;
    logic        w_out_free;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                   input logic [31:0] step,
                                                   input logic neg);
        logic signed [33:0] s;
        logic signed [33:0] d;
        d = neg ? -$signed({2'b00, step}) : $signed({2'b00, step});
        s = {{2{acc[31]}}, acc} + d;
        if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
            return s[31:0];
        end
        return s[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [17:0] ang_delta(input logic [15:0] cur,
                                                     input logic [15:0] prev);
        logic signed [17:0] diff;
        diff = $signed({2'b00, cur}) - $signed({2'b00, prev});
        if (diff > $signed({1'b0, eodo_pkg::ANG_HALF})) begin
            return diff - 18'sd65536;
        end else if (diff < -$signed({1'b0, eodo_pkg::ANG_HALF})) begin
            return diff + 18'sd65536;
        end
        return diff;
    endfunction

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_pos_x     = r_ox;
    assign o_pos_y     = r_oy;
    assign o_heading   = r_oh;
    assign w_out_free  = !r_ovalid || !i_out_stall;

    assign w_dl  = ang_delta(i_left_angle, r_prev_l);
    assign w_dr  = ang_delta(i_right_angle, r_prev_r);
    assign w_dd  = 19'(w_dr) - 19'(w_dl);
    assign w_sum = 19'(w_dr) + 19'(w_dl);

    assign w_quad = r_head[31:30];
    assign w_f    = r_head[29:0];
    assign w_fold = w_f > eodo_pkg::EIGHTH;
    assign w_g    = w_fold ? 30'(eodo_pkg::QUARTER - {1'b0, w_f}) : w_f;
    assign w_ssel = w_fold ? r_c0 : r_s0;
    assign w_csel = w_fold ? r_s0 : r_c0;

    always_comb begin
        case (w_quad)
            2'd0: begin
                w_smag = w_ssel; w_sneg = 1'b0; w_cmag = w_csel; w_cneg = 1'b0;
            end
            2'd1: begin
                w_smag = w_csel; w_sneg = 1'b0; w_cmag = w_ssel; w_cneg = 1'b1;
            end
            2'd2: begin
                w_smag = w_ssel; w_sneg = 1'b1; w_cmag = w_csel; w_cneg = 1'b1;
            end
            default: begin
                w_smag = w_csel; w_sneg = 1'b1; w_cmag = w_ssel; w_cneg = 1'b0;
            end
        endcase
    end

    assign w_hstep = r_pp[63:32] + {31'd0, r_pp[31]};
    assign w_pstep = r_pp[78:47] + {31'd0, r_pp[46]};

    always_comb begin
        c_is_div = 1'b0;
        c_a      = '0;
        c_b      = '0;
        c_num    = r_pp[60:30];
        c_den    = 6'd2;
        c_next   = S_IDLE;
        unique case (r_state)
            S_MDD:  begin c_a = {24'd0, r_dpc}; c_b = {16'd0, r_dd_mag}; c_next = S_MIWB; end
            S_MIWB: begin c_a = r_m; c_b = {9'd0, r_iwb}; c_next = S_MK; end
            S_MK:   begin c_a = r_m; c_b = {3'd0, eodo_pkg::INV_TWO_PI}; c_next = S_MR; end
            S_MR:   begin
                c_a = {23'd0, eodo_pkg::TWO_PI_Q30}; c_b = {3'd0, w_g}; c_next = S_MR2;
            end
            S_MR2:  begin c_a = {26'd0, r_r}; c_b = {3'd0, r_r}; c_next = S_DS1; end
            S_DS1:  begin
                c_is_div = 1'b1; c_num = {1'b0, r_r2}; c_den = 6'd42; c_next = S_MS1;
            end
            S_MS1:  begin c_a = {26'd0, r_r2}; c_b = {2'd0, r_t}; c_next = S_DS2; end
            S_DS2:  begin c_is_div = 1'b1; c_den = 6'd20; c_next = S_MS2; end
            S_MS2:  begin c_a = {26'd0, r_r2}; c_b = {2'd0, r_t}; c_next = S_DS3; end
            S_DS3:  begin c_is_div = 1'b1; c_den = 6'd6; c_next = S_MS0; end
            S_MS0:  begin c_a = {26'd0, r_r}; c_b = {2'd0, r_t}; c_next = S_DC1; end
            S_DC1:  begin
                c_is_div = 1'b1; c_num = {1'b0, r_r2}; c_den = 6'd56; c_next = S_MC1;
            end
            S_MC1:  begin c_a = {26'd0, r_r2}; c_b = {2'd0, r_t}; c_next = S_DC2; end
            S_DC2:  begin c_is_div = 1'b1; c_den = 6'd30; c_next = S_MC2; end
            S_MC2:  begin c_a = {26'd0, r_r2}; c_b = {2'd0, r_t}; c_next = S_DC3; end
            S_DC3:  begin c_is_div = 1'b1; c_den = 6'd12; c_next = S_MC3; end
            S_MC3:  begin c_a = {26'd0, r_r2}; c_b = {2'd0, r_t}; c_next = S_DC4; end
            S_DC4:  begin c_is_div = 1'b1; c_den = 6'd2; c_next = S_MSUM; end
            S_MSUM: begin
                c_a = {24'd0, r_dpc}; c_b = {16'd0, r_sum_mag}; c_next = S_MX;
            end
            S_MX:   begin c_a = r_m; c_b = {2'd0, w_cmag}; c_next = S_MY; end
            S_MY:   begin c_a = r_m; c_b = {2'd0, w_smag}; c_next = S_POST; end
            S_IDLE, S_POST: begin c_next = S_IDLE; end
            default: begin c_next = S_IDLE; end
        endcase
    end

    assign n_add = {1'b0, r_pp[eodo_pkg::MUL_P_W-1:eodo_pkg::MUL_B_W]}
                 + (r_pp[0] ? {1'b0, r_pa} : '0);
    assign n_pp  = {n_add, r_pp[eodo_pkg::MUL_B_W-1:1]};

    assign n_sh  = {r_rem, r_dq[eodo_pkg::DIV_W-1]};
    assign n_sub = {1'b0, n_sh} - {2'b00, r_den};
    assign n_ok  = !n_sub[eodo_pkg::DEN_W+1];
    assign n_rem = n_ok ? n_sub[eodo_pkg::DEN_W-1:0] : n_sh[eodo_pkg::DEN_W-1:0];
    assign n_dq  = {r_dq[eodo_pkg::DIV_W-2:0], n_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph      <= PH_LOAD;
            r_cnt     <= '0;
            r_dpc     <= eodo_pkg::DPC_RESET;
            r_iwb     <= eodo_pkg::IWB_RESET;
            r_started <= 1'b0;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_head    <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    eodo_pkg::CFG_DIST_PER_COUNT: r_dpc <= i_cfg_data;
                    eodo_pkg::CFG_INV_WHEEL_BASE: r_iwb <= i_cfg_data[23:0];
                    default: ;
                endcase
            end

            if (r_ovalid && !i_out_stall && r_state != S_POST) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_prev_l <= i_left_angle;
                        r_prev_r <= i_right_angle;
                        if (!r_started) begin
                            r_started <= 1'b1;
                        end else begin
                            r_dd_neg  <= w_dd[18];
                            r_dd_mag  <= 17'(w_dd[18] ? -w_dd : w_dd);
                            r_sum_neg <= w_sum[18];
                            r_sum_mag <= 17'(w_sum[18] ? -w_sum : w_sum);
                            r_state   <= S_MDD;
                            r_ph      <= PH_LOAD;
                        end
                    end
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_ox     <= r_x;
                        r_oy     <= r_y;
                        r_oh     <= r_head;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    unique case (r_ph)
                        PH_LOAD: begin
                            r_pa  <= c_a;
                            r_pp  <= {{eodo_pkg::MUL_A_W{1'b0}}, c_b};
                            r_dq  <= c_num;
                            r_den <= c_den;
                            r_rem <= '0;
                            r_cnt <= '0;
                            r_ph  <= PH_RUN;
                        end
                        PH_RUN: begin
                            if (c_is_div) begin
                                r_dq  <= n_dq;
                                r_rem <= n_rem;
                            end else begin
                                r_pp <= n_pp;
                            end
                            r_cnt <= r_cnt + 1'b1;
                            if ((c_is_div && r_cnt == eodo_pkg::CNT_W'(eodo_pkg::DIV_W - 1))
                                || (!c_is_div
                                    && r_cnt == eodo_pkg::CNT_W'(eodo_pkg::MUL_B_W - 1))) begin
                                r_ph <= PH_FIN;
                            end
                        end
                        default: begin
                            case (r_state)
                                S_MDD:  r_m <= r_pp[55:0];
                                S_MIWB: r_m <= r_pp[71:16] + {55'd0, r_pp[15]};
                                S_MK:   r_head <= r_dd_neg ? r_head - w_hstep
                                                           : r_head + w_hstep;
                                S_MR:   r_r <= r_pp[61:32] + {29'd0, r_pp[31]};
                                S_MR2:  r_r2 <= r_pp[59:30] + {29'd0, r_pp[29]};
                                S_DS1, S_DS2, S_DS3, S_DC1, S_DC2, S_DC3:
                                        r_t <= eodo_pkg::ONE_Q30 - r_dq;
                                S_DC4:  r_c0 <= eodo_pkg::ONE_Q30 - r_dq;
                                S_MS0:  r_s0 <= r_pp[60:30];
                                S_MSUM: r_m <= r_pp[55:0];
                                S_MX:   r_x <= sat_add(r_x, w_pstep, r_sum_neg ^ w_cneg);
                                S_MY:   r_y <= sat_add(r_y, w_pstep, r_sum_neg ^ w_sneg);
                                default: ;
                            endcase
                            r_ph    <= PH_LOAD;
                            r_state <= c_next;
                        end
                    endcase
                end
            endcase
        end
    end

    a_first_item_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_started) |=> (r_state == S_IDLE && r_started))
        else $error("first item must only initialize");

    a_item_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_started) |=> (r_state == S_MDD && r_ph == PH_LOAD))
        else $error("item after the first must start the sequencer");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_RUN) |-> (r_cnt < eodo_pkg::CNT_W'(eodo_pkg::MUL_B_W)))
        else $error("serial step counter out of range");

    a_post_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && w_out_free) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished result not moved to the output register");

    a_heading_only_in_mk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_MK && r_ph == PH_FIN) |=> $stable(r_head))
        else $error("heading changed outside its update step");

endmodule
